@@ rtl/assert_macros.svh @@
// assertion macros shared by the button debounce rtl
// each macro samples on clk and is disabled while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define BDLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent implies consequent on the next clock edge
`define BDLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/bdlp_pkg.sv @@
// types, constants and helpers for the button debounce / long press / repeat block
// no dependencies
`timescale 1ns / 1ps

package bdlp_pkg;

  localparam int COUNT_WIDTH     = 16;
  localparam int CFG_WIDTH       = 16;
  localparam int CMP_WIDTH       = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int EV_WIDTH        = 3;
  localparam int PHASE_WIDTH     = 3;

  // register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LONG_PRESS = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_REPEAT     = 2'd2;

  // register reset values
  localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET   = 16'd50;
  localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET = 16'd1000;
  localparam logic [CFG_WIDTH-1:0] REPEAT_RESET     = 16'd200;

  // external phase codes
  localparam logic [PHASE_WIDTH-1:0] PH_IDLE     = 3'd0;
  localparam logic [PHASE_WIDTH-1:0] PH_DEBOUNCE = 3'd1;
  localparam logic [PHASE_WIDTH-1:0] PH_PRESSED  = 3'd2;
  localparam logic [PHASE_WIDTH-1:0] PH_LONG     = 3'd3;
  localparam logic [PHASE_WIDTH-1:0] PH_REPEAT   = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_DEBOUNCE = 5'b00010,
    ST_PRESSED  = 5'b00100,
    ST_LONG     = 5'b01000,
    ST_REPEAT   = 5'b10000
  } state_t;

  typedef enum logic [EV_WIDTH-1:0] {
    EV_NONE   = 3'd0,
    EV_PRESS  = 3'd1,
    EV_LONG   = 3'd2,
    EV_REPEAT = 3'd3,
    EV_IDLE   = 3'd4
  } event_t;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] debounce_ticks;
    logic [CFG_WIDTH-1:0] long_press_ticks;
    logic [CFG_WIDTH-1:0] repeat_ticks;
  } cfg_t;

  typedef struct packed {
    logic [EV_WIDTH-1:0]    event_code;
    logic [PHASE_WIDTH-1:0] phase;
  } result_t;

  function automatic logic [PHASE_WIDTH-1:0] phase_code(input state_t st);
    logic [PHASE_WIDTH-1:0] code;
    unique case (st)
      ST_IDLE:     code = PH_IDLE;
      ST_DEBOUNCE: code = PH_DEBOUNCE;
      ST_PRESSED:  code = PH_PRESSED;
      ST_LONG:     code = PH_LONG;
      ST_REPEAT:   code = PH_REPEAT;
      default:     code = PH_IDLE;
    endcase
    return code;
  endfunction

endpackage

@@ rtl/bdlp_cfg_regs.sv @@
// threshold registers written through the plain configuration port
// depends on bdlp_pkg
`timescale 1ns / 1ps

module bdlp_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [bdlp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [bdlp_pkg::CFG_WIDTH-1:0]       cfg_wdata,
  output bdlp_pkg::cfg_t                       cfg
);
  import bdlp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks   <= DEBOUNCE_RESET;
      cfg.long_press_ticks <= LONG_PRESS_RESET;
      cfg.repeat_ticks     <= REPEAT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_DEBOUNCE:   cfg.debounce_ticks   <= cfg_wdata;
        REG_LONG_PRESS: cfg.long_press_ticks <= cfg_wdata;
        REG_REPEAT:     cfg.repeat_ticks     <= cfg_wdata;
        default:        ;  // unmapped index, write dropped
      endcase
    end
  end

endmodule

@@ rtl/bdlp_fsm.sv @@
// phase state machine and saturating tick counter, one step per accepted beat
// depends on bdlp_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bdlp_fsm (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              pin_level,
  input  bdlp_pkg::cfg_t    cfg,
  output bdlp_pkg::result_t result
);
  import bdlp_pkg::*;

  state_t                 state;
  state_t                 state_next;
  logic [COUNT_WIDTH-1:0] elapsed;
  logic [COUNT_WIDTH-1:0] elapsed_next;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [CFG_WIDTH-1:0]   thr;
  logic                   expired;
  logic                   held;
  event_t                 ev;

  assign held    = ~pin_level;
  assign cnt_inc = (elapsed == {COUNT_WIDTH{1'b1}}) ? elapsed : elapsed + 1'b1;

  // one threshold per phase, one compare
  always_comb begin
    case (state)
      ST_DEBOUNCE: thr = cfg.debounce_ticks;
      ST_PRESSED:  thr = cfg.long_press_ticks;
      default:     thr = cfg.repeat_ticks;
    endcase
  end

  assign expired = CMP_WIDTH'(cnt_inc) >= CMP_WIDTH'(thr);

  always_comb begin
    state_next   = state;
    elapsed_next = cnt_inc;
    ev           = EV_NONE;
    unique case (state)
      ST_IDLE: begin
        if (held) begin
          state_next   = ST_DEBOUNCE;
          elapsed_next = '0;
        end
      end
      ST_DEBOUNCE: begin
        if (expired) begin
          if (held) begin
            state_next   = ST_PRESSED;
            elapsed_next = '0;
            ev           = EV_PRESS;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_PRESSED: begin
        // long press wins over a release on the same tick
        if (expired) begin
          state_next   = ST_LONG;
          elapsed_next = '0;
          ev           = EV_LONG;
        end else if (!held) begin
          state_next = ST_IDLE;
          ev         = EV_IDLE;
        end
      end
      ST_LONG, ST_REPEAT: begin
        if (!held) begin
          state_next = ST_IDLE;
          ev         = EV_IDLE;
        end else if (expired) begin
          state_next   = ST_REPEAT;
          elapsed_next = '0;
          ev           = EV_REPEAT;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign result.event_code = ev;
  assign result.phase      = phase_code(state_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      elapsed <= '0;
    end else if (accept) begin
      state   <= state_next;
      elapsed <= elapsed_next;
    end
  end

  // press, long press and repeat all clear the counter
  `BDLP_ASSERT_NEXT(a_mark_clears_count,
    accept && (ev == EV_PRESS || ev == EV_LONG || ev == EV_REPEAT),
    elapsed == '0, "event did not clear tick counter")
  // release event always lands in idle
  `BDLP_ASSERT_NEXT(a_release_to_idle, accept && ev == EV_IDLE,
    state == ST_IDLE, "release event without return to idle")
  // no beat, no change
  `BDLP_ASSERT_NEXT(a_hold_without_beat, !accept,
    $stable(state) && $stable(elapsed), "state moved without a beat")

endmodule

@@ rtl/bdlp_out_buf.sv @@
// two-entry result buffer: output register plus skid stage
// depends on bdlp_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bdlp_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bdlp_pkg::result_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bdlp_pkg::result_t out_data
);
  import bdlp_pkg::*;

  result_t skid_data;
  logic    skid_valid;
  logic    in_acc;
  logic    slot_free;

  assign in_ready  = ~skid_valid;
  assign in_acc    = in_valid & in_ready;
  assign slot_free = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (slot_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= in_acc;
      end else begin
        out_valid <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid <= 1'b1;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
        if (in_acc) begin
          skid_data <= in_data;
        end
      end else if (in_acc) begin
        out_data <= in_data;
      end
    end else if (in_acc) begin
      skid_data <= in_data;
    end
  end

  `BDLP_ASSERT(a_skid_behind_out, !skid_valid || out_valid,
    "skid holds a beat while output is empty")
  `BDLP_ASSERT_NEXT(a_skid_refills_out, skid_valid && out_ready, out_valid,
    "skid beat not moved to output")

endmodule

@@ rtl/button_debounce_long_press_repeat_core.sv @@
// top level of the button debouncer with long press and auto repeat
// depends on bdlp_pkg, bdlp_cfg_regs, bdlp_fsm, bdlp_out_buf
`timescale 1ns / 1ps

// usage
//   input channel (in_valid/in_ready): one beat per time tick, pin_level is the
//   sampled active-low button level (0 pressed, 1 released)
//   output channel (out_valid/out_ready): exactly one beat per input beat,
//   event_code (0 none, 1 press, 2 long press, 3 repeat, 4 released) and
//   phase after the tick (0 idle, 1 debounce, 2 pressed, 3 long, 4 repeat)
//   config port: cfg_wr_en with cfg_index 0 debounce, 1 long press, 2 repeat
//   ticks; index 3 is ignored; write only while no beat is in flight
// timing
//   state and counter update in the cycle of acceptance; the result is registered
//   in the output register, or in the skid stage while the output is stalled
//   throughput one beat per cycle while in_ready is high, set by the state/counter update
// stall
//   a two-entry output buffer absorbs one beat while out_ready is low; in_ready
//   drops only once both entries are full
// reset
//   rst (synchronous) clears the phase to idle, the tick counter to zero, the
//   thresholds to 50/1000/200 and empties the output buffer
module button_debounce_long_press_repeat_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 pin_level,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [bdlp_pkg::EV_WIDTH-1:0]        event_code,
  output logic [bdlp_pkg::PHASE_WIDTH-1:0]     phase,
  input  logic                                 cfg_wr_en,
  input  logic [bdlp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [bdlp_pkg::CFG_WIDTH-1:0]       cfg_wdata
);
  import bdlp_pkg::*;

  cfg_t    cfg;
  result_t step_result;
  result_t out_data;
  logic    accept;

  // a beat is taken whenever the buffer has room
  assign accept = in_valid & in_ready;

  bdlp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // next phase, counter and event from the current state and this tick
  bdlp_fsm u_fsm (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .pin_level (pin_level),
    .cfg       (cfg),
    .result    (step_result)
  );

  // result register with skid stage
  bdlp_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (step_result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign event_code = out_data.event_code;
  assign phase      = out_data.phase;

endmodule
